[design/nbpa_pkg.sv]
// Package with constants, request/response types and helpers for the port bitmap allocator.
`default_nettype none

package nbpa_pkg;

    localparam int POOLS          = 4;
    localparam int WORD_BITS      = 11;
    localparam int WORDS_PER_POOL = 1 << WORD_BITS;
    localparam int RESERVED_WORDS = 32;
    localparam int MEM_DEPTH      = POOLS * WORDS_PER_POOL;
    localparam int MEM_AW         = $clog2(MEM_DEPTH);
    localparam int PW             = (POOLS > 1) ? $clog2(POOLS) : 1;

    localparam logic [15:0] DEFAULT_LOW  = 16'd1024;
    localparam logic [15:0] DEFAULT_HIGH = 16'd65535;
    localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

    localparam logic [1:0] ACT_INIT  = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_FREE  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  pool;
        logic [15:0] port;
        logic [15:0] range_low;
        logic [15:0] range_high;
    } req_t;

    typedef struct packed {
        logic [15:0] granted_port;
        logic        ok;
        logic [16:0] in_use_count;
        logic [31:0] success_count;
        logic [31:0] failure_count;
    } rsp_t;

    // Lowest set bit of a 32-bit word, with a found flag in the top bit.
    function automatic logic [5:0] first_set(input logic [31:0] v);
        logic [5:0] r;
        r = 6'd0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                r = {1'b1, 5'(i)};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/nat_port_bitmap_allocator_core.sv]
// Top level of the NAT port bitmap allocator: sequencer, pool registers and bitmap memory.
`default_nettype none

// Each pool owns 2048 words of 32 bits in one synchronous bitmap RAM, one bit per
// port (1 means in use), plus range, search hint and counter registers. Requests are
// handled one at a time and every request returns exactly one response. After reset
// a clearing pass writes the whole RAM, word by word, while req_ready stays low.
// Per request: a free reads the port's word and clears its bit if set; allocation of a
// free preferred port reads its word and then sets the bit; a scanning allocation
// starts from the hint or after a busy preferred port and reads one bitmap word at
// a time until it finds a free port or the range is exhausted; init takes the
// accept cycle and one RAM write per word of the pool. The single RAM read port,
// one word per cycle, sets the scan speed. A response waits in an output register;
// the next request is taken once that register is empty or being drained.
module nat_port_bitmap_allocator_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire nbpa_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output nbpa_pkg::rsp_t     rsp
);
    import nbpa_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_INIT  = 3'd2;
    localparam logic [2:0] ST_PREF  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_FREE  = 3'd5;

    // Sequencer and per-request registers.
    logic [2:0]        state_reg, state_next;
    logic [MEM_AW-1:0] clr_reg, clr_next;
    logic [WORD_BITS-1:0] sweep_reg, sweep_next;
    logic [PW-1:0]     pidx_reg, pidx_next;
    logic [15:0]       pref_reg, pref_next;
    logic [15:0]       cur_reg, cur_next;
    logic [15:0]       st_reg, st_next;
    logic              phase_reg, phase_next;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // Per-pool state.
    logic [15:0] low_reg   [POOLS];
    logic [15:0] high_reg  [POOLS];
    logic [15:0] hint_reg  [POOLS];
    logic [16:0] inuse_reg [POOLS];
    logic [31:0] succ_reg  [POOLS];
    logic [31:0] fail_reg  [POOLS];

    // Pool update commands from the sequencer.
    logic        upd_init, upd_grant, upd_fail, upd_dec, upd_hint;
    logic [15:0] hint_val;

    // Bitmap RAM port.
    logic              ram_we;
    logic [MEM_AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]       ram_wdata, ram_rdata;

    nbpa_ram #(
        .WIDTH (32),
        .DEPTH (MEM_DEPTH)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic logic [MEM_AW-1:0] word_addr(input logic [PW-1:0] p,
                                                    input logic [15:0] prt);
        return (MEM_AW'(p) << WORD_BITS) | MEM_AW'(prt[15:5]);
    endfunction

    logic          acc;
    logic          pool_ok;
    logic [PW-1:0] ipidx;
    logic [15:0]   lo_q, hi_q, init_lo, init_hi, hint_start, par_start, upper;
    logic [16:0]   cur_inuse;
    logic [31:0]   cur_succ, cur_fail;
    logic [31:0]   scan_mask, free_bits, bit_mask;
    logic [5:0]    hit;
    logic [15:0]   hit_port;
    logic [16:0]   hit_plus;

    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign acc       = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        // Defaults: hold everything.
        state_next     = state_reg;
        clr_next       = clr_reg;
        sweep_next     = sweep_reg;
        pidx_next      = pidx_reg;
        pref_next      = pref_reg;
        cur_next       = cur_reg;
        st_next        = st_reg;
        phase_next     = phase_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        upd_init       = 1'b0;
        upd_grant      = 1'b0;
        upd_fail       = 1'b0;
        upd_dec        = 1'b0;
        upd_hint       = 1'b0;
        hint_val       = 16'd0;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;

        // In idle the pool comes from the request, otherwise from the latched index.
        ipidx     = (state_reg == ST_IDLE) ? PW'(req.pool) : pidx_reg;
        pool_ok   = (32'(req.pool) < POOLS);
        lo_q      = low_reg[ipidx];
        hi_q      = high_reg[ipidx];
        cur_inuse = inuse_reg[ipidx];
        cur_succ  = succ_reg[ipidx];
        cur_fail  = fail_reg[ipidx];

        init_lo = (req.range_low  != 16'd0) ? req.range_low  : DEFAULT_LOW;
        init_hi = (req.range_high != 16'd0) ? req.range_high : DEFAULT_HIGH;

        // The hint always lies in the range; clamp anyway if it does not.
        hint_start = (hint_reg[ipidx] < lo_q || hint_reg[ipidx] > hi_q) ? lo_q
                                                                        : hint_reg[ipidx];

        // Busy preferred port: start at the first port of its parity.
        if (lo_q[0] == pref_reg[0])
        begin
            par_start = lo_q;
        end
        else
        begin
            par_start = ({1'b0, lo_q} + 17'd1 > {1'b0, hi_q}) ? lo_q : lo_q + 16'd1;
        end

        // Scan window in the current word: from cur up to the phase limit.
        upper     = phase_reg ? (st_reg - 16'd1) : hi_q;
        scan_mask = ALL_ONES << cur_reg[4:0];
        if (upper[15:5] == cur_reg[15:5])
        begin
            scan_mask = scan_mask & (ALL_ONES >> (5'd31 - upper[4:0]));
        end
        free_bits = ~ram_rdata & scan_mask;
        hit       = first_set(free_bits);
        hit_port  = {cur_reg[15:5], hit[4:0]};
        hit_plus  = {1'b0, hit_port} + 17'd1;

        bit_mask = 32'd1 << pref_reg[4:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = (32'(clr_reg[WORD_BITS-1:0]) < RESERVED_WORDS) ? ALL_ONES : 32'd0;
                clr_next  = clr_reg + MEM_AW'(1);
                if (32'(clr_reg) == MEM_DEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (acc)
                begin
                    pidx_next = ipidx;
                    pref_next = req.port;
                    rsp_next  = '{granted_port: 16'd0, ok: 1'b0, in_use_count: cur_inuse,
                                  success_count: cur_succ, failure_count: cur_fail};
                    if (!pool_ok)
                    begin
                        rsp_next       = '0;
                        rsp_valid_next = 1'b1;
                    end
                    else
                    begin
                        case (req.action)
                            ACT_INIT:
                            begin
                                if (init_hi >= init_lo)
                                begin
                                    cur_next   = init_lo;
                                    st_next    = init_hi;
                                    sweep_next = '0;
                                    state_next = ST_INIT;
                                end
                                else
                                begin
                                    rsp_valid_next = 1'b1;
                                end
                            end
                            ACT_ALLOC:
                            begin
                                if (req.port >= lo_q && req.port <= hi_q)
                                begin
                                    ram_raddr  = word_addr(ipidx, req.port);
                                    state_next = ST_PREF;
                                end
                                else
                                begin
                                    st_next    = hint_start;
                                    cur_next   = hint_start;
                                    phase_next = 1'b0;
                                    ram_raddr  = word_addr(ipidx, hint_start);
                                    state_next = ST_SCAN;
                                end
                            end
                            ACT_FREE:
                            begin
                                if (req.port >= DEFAULT_LOW)
                                begin
                                    ram_raddr  = word_addr(ipidx, req.port);
                                    state_next = ST_FREE;
                                end
                                else
                                begin
                                    rsp_valid_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                rsp_valid_next = 1'b1;
                            end
                        endcase
                    end
                end
            end

            ST_INIT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = (MEM_AW'(pidx_reg) << WORD_BITS) | MEM_AW'(sweep_reg);
                ram_wdata  = (32'(sweep_reg) < RESERVED_WORDS) ? ALL_ONES : 32'd0;
                sweep_next = sweep_reg + WORD_BITS'(1);
                if (32'(sweep_reg) == WORDS_PER_POOL - 1)
                begin
                    upd_init       = 1'b1;
                    rsp_next       = '{granted_port: 16'd0, ok: 1'b1, in_use_count: 17'd0,
                                       success_count: 32'd0, failure_count: 32'd0};
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_PREF:
            begin
                if (!ram_rdata[pref_reg[4:0]])
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = word_addr(pidx_reg, pref_reg);
                    ram_wdata      = ram_rdata | bit_mask;
                    upd_grant      = 1'b1;
                    rsp_next       = '{granted_port: pref_reg, ok: 1'b1,
                                       in_use_count: cur_inuse + 17'd1,
                                       success_count: cur_succ + 32'd1,
                                       failure_count: cur_fail};
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    st_next    = par_start;
                    cur_next   = par_start;
                    phase_next = 1'b0;
                    ram_raddr  = word_addr(pidx_reg, par_start);
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (hit[5])
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = word_addr(pidx_reg, cur_reg);
                    ram_wdata      = ram_rdata | (32'd1 << hit[4:0]);
                    upd_grant      = 1'b1;
                    upd_hint       = 1'b1;
                    hint_val       = (hit_plus > {1'b0, hi_q}) ? lo_q : hit_plus[15:0];
                    rsp_next       = '{granted_port: hit_port, ok: 1'b1,
                                       in_use_count: cur_inuse + 17'd1,
                                       success_count: cur_succ + 32'd1,
                                       failure_count: cur_fail};
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (upper[15:5] != cur_reg[15:5])
                begin
                    // Move on to the start of the next word.
                    cur_next  = {cur_reg[15:5] + 11'd1, 5'd0};
                    ram_raddr = word_addr(pidx_reg, {cur_reg[15:5] + 11'd1, 5'd0});
                end
                else if (!phase_reg && st_reg != lo_q)
                begin
                    // Wrap to the bottom of the range, stop short of the start.
                    phase_next = 1'b1;
                    cur_next   = lo_q;
                    ram_raddr  = word_addr(pidx_reg, lo_q);
                end
                else
                begin
                    upd_fail       = 1'b1;
                    rsp_next       = '{granted_port: 16'd0, ok: 1'b0, in_use_count: cur_inuse,
                                       success_count: cur_succ,
                                       failure_count: cur_fail + 32'd1};
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_FREE:
            begin
                rsp_next = '{granted_port: 16'd0, ok: 1'b0, in_use_count: cur_inuse,
                             success_count: cur_succ, failure_count: cur_fail};
                if (ram_rdata[pref_reg[4:0]])
                begin
                    ram_we                = 1'b1;
                    ram_waddr             = word_addr(pidx_reg, pref_reg);
                    ram_wdata             = ram_rdata & ~bit_mask;
                    upd_dec               = 1'b1;
                    rsp_next.ok           = 1'b1;
                    rsp_next.in_use_count = (cur_inuse != 17'd0) ? cur_inuse - 17'd1 : cur_inuse;
                end
                rsp_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int p = 0; p < POOLS; p++)
            begin
                low_reg[p]   <= DEFAULT_LOW;
                high_reg[p]  <= DEFAULT_HIGH;
                hint_reg[p]  <= DEFAULT_LOW;
                inuse_reg[p] <= 17'd0;
                succ_reg[p]  <= 32'd0;
                fail_reg[p]  <= 32'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
            if (upd_init)
            begin
                low_reg[pidx_reg]   <= cur_reg;
                high_reg[pidx_reg]  <= st_reg;
                hint_reg[pidx_reg]  <= cur_reg;
                inuse_reg[pidx_reg] <= 17'd0;
                succ_reg[pidx_reg]  <= 32'd0;
                fail_reg[pidx_reg]  <= 32'd0;
            end
            if (upd_grant)
            begin
                inuse_reg[pidx_reg] <= inuse_reg[pidx_reg] + 17'd1;
                succ_reg[pidx_reg]  <= succ_reg[pidx_reg] + 32'd1;
            end
            if (upd_hint)
            begin
                hint_reg[pidx_reg] <= hint_val;
            end
            if (upd_fail)
            begin
                fail_reg[pidx_reg] <= fail_reg[pidx_reg] + 32'd1;
            end
            if (upd_dec && inuse_reg[pidx_reg] != 17'd0)
            begin
                inuse_reg[pidx_reg] <= inuse_reg[pidx_reg] - 17'd1;
            end
        end
    end

    // Per-request payload registers.
    always_ff @(posedge clk)
    begin
        sweep_reg <= sweep_next;
        pidx_reg  <= pidx_next;
        pref_reg  <= pref_next;
        cur_reg   <= cur_next;
        st_reg    <= st_next;
        phase_reg <= phase_next;
        rsp_reg   <= rsp_next;
    end

endmodule

`default_nettype wire

[design/nbpa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module nbpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
